### sv/activation_tanh_leaky_unit_macros.svh
// ----------------------------------------------------------------------------
// activation_tanh_leaky_unit assertion macros
// Concurrent check helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ACTIVATION_TANH_LEAKY_UNIT_MACROS_SVH
`define ACTIVATION_TANH_LEAKY_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ATLU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ATLU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ATLU_ASSERT_IMP(lbl, ante, cons)
`define ATLU_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### sv/atlu_pkg.sv
// ----------------------------------------------------------------------------
// atlu_pkg
// Shared types and fixed constants of the tanh / leaky activation unit.
// ----------------------------------------------------------------------------
package atlu_pkg;

  // sample width
  localparam int DATA_W = 16;

  // request operation codes
  typedef enum logic [1:0] {
    OP_EVAL     = 2'd0,
    OP_WR_BASE  = 2'd1,
    OP_WR_SLOPE = 2'd2
  } op_t;

  // configuration register indexes
  localparam logic CFG_ACT_MODE     = 1'b0;
  localparam logic CFG_PREACT_SHIFT = 1'b1;

  // tanh domain conversion and saturation levels
  localparam int TANH_Q = 14;
  localparam logic signed [DATA_W-1:0] SAT_POS = 16'sd32767;
  localparam logic signed [DATA_W-1:0] SAT_NEG = -16'sd32767;
  localparam logic signed [DATA_W-1:0] SAT_MIN = -16'sd32768;

  // leaky slope in Q15 with round-half-up
  localparam int LEAKY_SLOPE = 328;
  localparam int LEAKY_ROUND = 16384;
  localparam int LEAKY_SHIFT = 15;

  // decoded sample from the index stage
  typedef struct packed {
    logic                     sat_pos;
    logic                     sat_neg;
    logic signed [DATA_W-1:0] leaky;
  } prep_t;

endpackage

### sv/atlu_ram.sv
// ----------------------------------------------------------------------------
// atlu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module atlu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/atlu_prep.sv
// ----------------------------------------------------------------------------
// atlu_prep
// Moves a sample into the tanh table domain and computes the leaky result.
// ----------------------------------------------------------------------------
module atlu_prep #(
  parameter int SEGMENTS  = 4096,
  parameter int FRAC_BITS = 6
) (
  input  logic signed [atlu_pkg::DATA_W-1:0] sample,
  input  logic signed [5:0]                  preact_shift,
  output logic [$clog2(SEGMENTS)-1:0]        seg_addr,
  output logic [FRAC_BITS-1:0]               frac,
  output atlu_pkg::prep_t                    prep
);

  localparam int AW    = $clog2(SEGMENTS);
  localparam int DW    = atlu_pkg::DATA_W;
  // any nonzero sample shifted left this far is out of range
  localparam int LMAX  = AW + FRAC_BITS;
  localparam int LSW   = $clog2(LMAX + 1);
  localparam int W     = DW + LMAX + 1;
  localparam int LIM   = (SEGMENTS / 2) << FRAC_BITS;
  localparam logic signed [W-1:0] LIM_HI  = W'(LIM - 1);
  localparam logic signed [W-1:0] LIM_LO  = W'(-LIM);
  localparam logic signed [W-1:0] SEG_MID = W'(SEGMENTS / 2);
  localparam int LKW   = 26;

  logic signed [6:0]     to_q;
  logic [6:0]            q_u;
  logic [6:0]            r_u;
  logic [LSW-1:0]        lsh;
  logic signed [W-1:0]   c_ext;
  logic signed [W-1:0]   v;
  logic signed [W-1:0]   v_seg;
  logic signed [W-1:0]   seg_sum;
  logic signed [LKW-1:0] lk_sum;
  logic signed [LKW-1:0] lk_sh;

  // shift amount into the table domain
  assign to_q  = $signed({preact_shift[5], preact_shift}) + 7'(atlu_pkg::TANH_Q);
  assign q_u   = to_q;
  assign r_u   = 7'(-to_q);
  assign c_ext = $signed({{(W-DW){sample[DW-1]}}, sample});

  // exact left shift (clamped) or flooring right shift
  always_comb begin
    if (q_u > 7'(LMAX)) begin
      lsh = LSW'(LMAX);
    end else begin
      lsh = LSW'(q_u);
    end
    if (!to_q[6]) begin
      v = c_ext <<< lsh;
    end else begin
      v = c_ext >>> r_u;
    end
  end

  // segment and fraction
  assign v_seg    = v >>> FRAC_BITS;
  assign seg_sum  = v_seg + SEG_MID;
  assign seg_addr = seg_sum[AW-1:0];
  assign frac     = v[FRAC_BITS-1:0];

  // range limits
  assign prep.sat_pos = (v >= LIM_HI);
  assign prep.sat_neg = (v <= LIM_LO);

  // leaky branch for negative samples, result always fits 16 bits
  assign lk_sum = $signed({{(LKW-DW){sample[DW-1]}}, sample})
                * $signed(LKW'(atlu_pkg::LEAKY_SLOPE))
                + $signed(LKW'(atlu_pkg::LEAKY_ROUND));
  assign lk_sh  = lk_sum >>> atlu_pkg::LEAKY_SHIFT;
  assign prep.leaky = sample[DW-1] ? lk_sh[DW-1:0] : sample;

endmodule

### sv/activation_tanh_leaky_unit.sv
// ----------------------------------------------------------------------------
// activation_tanh_leaky_unit
// Int16 activation: piecewise-linear tanh from loadable tables, or LeakyReLU.
// ----------------------------------------------------------------------------
// Takes one request per clock while results are taken (a stalled out_tready
// back-pressures in_tready) and gives one result per evaluate request; table
// writes and unused operations give none. An evaluate result passes the input
// register, which loads at the accepting edge, then the table RAMs' registered
// read and the output register. A table write is visible to every evaluate
// request accepted after it. Table entries are undefined until written, and
// there is no clearing pass after reset.
// Configuration writes take effect at once and are meant for idle periods.
module activation_tanh_leaky_unit #(
  parameter int SEGMENTS  = 4096,
  parameter int FRAC_BITS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  // input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // table_index[11:0], value[27:12], zero pad
  input  logic [1:0]  in_tuser,   // operation[1:0]
  input  logic        in_tlast,
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // activation[15:0]
  output logic        out_tlast,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_wdata
);

`include "activation_tanh_leaky_unit_macros.svh"

  localparam int AW = $clog2(SEGMENTS);
  localparam int DW = atlu_pkg::DATA_W;
  localparam int PW = DW + FRAC_BITS + 1;

  // configuration registers
  logic              act_mode_r;
  logic signed [5:0] preact_shift_r;

  // stage 1: input register
  logic                 s1_valid_r, s1_valid_nxt;
  logic [1:0]           s1_op_r;
  logic [11:0]          s1_index_r;
  logic signed [DW-1:0] s1_value_r;
  logic                 s1_last_r;

  // stage 2: table read data and decoded sample
  logic                 s2_valid_r, s2_valid_nxt;
  logic                 s2_mode_r;
  atlu_pkg::prep_t      s2_prep_r;
  logic [FRAC_BITS-1:0] s2_frac_r;
  logic                 s2_last_r;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [DW-1:0]        out_data_r;
  logic                 out_last_r;

  logic                 out_free, s2_move, s2_free, s1_move;
  logic                 s1_eval, s1_in_range;
  logic                 base_we, slope_we, tbl_re;
  logic [AW-1:0]        seg_addr;
  logic [FRAC_BITS-1:0] frac;
  atlu_pkg::prep_t      prep;
  logic [DW-1:0]        base_q, slope_q;

  logic signed [PW-1:0] slope_x, frac_x, prod, term;
  logic signed [PW:0]   tanh_sum;
  logic signed [DW-1:0] tanh_val, act_val;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_mode_r     <= 1'b0;
      preact_shift_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == atlu_pkg::CFG_ACT_MODE) begin
        act_mode_r <= cfg_wdata[0];
      end
      if (cfg_index == atlu_pkg::CFG_PREACT_SHIFT) begin
        preact_shift_r <= $signed(cfg_wdata);
      end
    end
  end

  // pipeline flow control, bubbles collapse
  assign out_free  = !out_valid_r || out_tready;
  assign s2_move   = s2_valid_r && out_free;
  assign s2_free   = !s2_valid_r || s2_move;
  assign s1_move   = s1_valid_r && s2_free;
  assign in_tready = !s1_valid_r || s1_move;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s2_valid_nxt  = s2_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
    if (s2_free) begin
      s2_valid_nxt = s1_move && s1_eval;
    end
    if (out_free) begin
      out_valid_nxt = s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r    <= in_tuser;
      s1_index_r <= in_tdata[11:0];
      s1_value_r <= $signed(in_tdata[27:12]);
      s1_last_r  <= in_tlast;
    end
  end

  // table domain index and leaky branch
  atlu_prep #(
    .SEGMENTS  (SEGMENTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .sample       (s1_value_r),
    .preact_shift (preact_shift_r),
    .seg_addr     (seg_addr),
    .frac         (frac),
    .prep         (prep)
  );

  // table access
  assign s1_eval     = (s1_op_r == atlu_pkg::OP_EVAL);
  assign s1_in_range = (32'(s1_index_r) < SEGMENTS);
  assign base_we     = s1_move && (s1_op_r == atlu_pkg::OP_WR_BASE) && s1_in_range;
  assign slope_we    = s1_move && (s1_op_r == atlu_pkg::OP_WR_SLOPE) && s1_in_range;
  assign tbl_re      = s1_move && s1_eval;

  atlu_ram #(
    .WIDTH (DW),
    .DEPTH (SEGMENTS)
  ) u_base_ram (
    .clk   (clk),
    .we    (base_we),
    .waddr (AW'(s1_index_r)),
    .wdata (s1_value_r),
    .re    (tbl_re),
    .raddr (seg_addr),
    .rdata (base_q)
  );

  atlu_ram #(
    .WIDTH (DW),
    .DEPTH (SEGMENTS)
  ) u_slope_ram (
    .clk   (clk),
    .we    (slope_we),
    .waddr (AW'(s1_index_r)),
    .wdata (s1_value_r),
    .re    (tbl_re),
    .raddr (seg_addr),
    .rdata (slope_q)
  );

  // stage 2 side data, aligned with the table read
  always_ff @(posedge clk) begin
    if (tbl_re) begin
      s2_mode_r <= act_mode_r;
      s2_prep_r <= prep;
      s2_frac_r <= frac;
      s2_last_r <= s1_last_r;
    end
  end

  // interpolation: base + floor(slope * frac / 2^FRAC_BITS)
  assign slope_x  = $signed({{(PW-DW){slope_q[DW-1]}}, slope_q});
  assign frac_x   = $signed({{(PW-FRAC_BITS){1'b0}}, s2_frac_r});
  assign prod     = slope_x * frac_x;
  assign term     = prod >>> FRAC_BITS;
  assign tanh_sum = $signed({term[PW-1], term})
                  + $signed({{(PW+1-DW){base_q[DW-1]}}, base_q});

  // int16 saturation and result select
  always_comb begin
    if (tanh_sum > $signed((PW+1)'(atlu_pkg::SAT_POS))) begin
      tanh_val = atlu_pkg::SAT_POS;
    end else if (tanh_sum < $signed((PW+1)'(atlu_pkg::SAT_MIN))) begin
      tanh_val = atlu_pkg::SAT_MIN;
    end else begin
      tanh_val = tanh_sum[DW-1:0];
    end
    if (s2_mode_r) begin
      act_val = s2_prep_r.leaky;
    end else if (s2_prep_r.sat_pos) begin
      act_val = atlu_pkg::SAT_POS;
    end else if (s2_prep_r.sat_neg) begin
      act_val = atlu_pkg::SAT_NEG;
    end else begin
      act_val = tanh_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_data_r <= act_val;
      out_last_r <= s2_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks
  `ATLU_ASSERT_NXT(a_s2_to_out, s2_valid_r && out_free, out_tvalid)
  `ATLU_ASSERT_NXT(a_eval_to_s2, s1_move && s1_eval, s2_valid_r)
  `ATLU_ASSERT_IMP(a_read_on_eval, tbl_re, s1_op_r == atlu_pkg::OP_EVAL)
  `ATLU_ASSERT_IMP(a_write_no_read, base_we || slope_we, !tbl_re && !(base_we && slope_we))

endmodule

### sim/tb_activation_tanh_leaky_unit.sv
// ----------------------------------------------------------------------------
// tb_activation_tanh_leaky_unit
// Self-checking bench for the tanh / leaky activation unit. Requests load the
// base and slope tables and evaluate samples under several mode and shift
// settings; every result is compared against an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module tb_activation_tanh_leaky_unit;

  localparam int SEGS         = 4096;
  localparam int FRAC         = 6;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 70;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1000000;

  // operation code the unit ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    SEG_INSIDE = 2'd0,
    SEG_TOP    = 2'd1,
    SEG_BOTTOM = 2'd2
  } seg_kind_t;

  typedef struct packed {
    seg_kind_t   kind;
    logic [11:0] idx;
    logic [5:0]  frac;
  } seg_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [11:0]        idx;
    logic signed [15:0] val;
    logic               last;
  } req_t;

  typedef struct packed {
    logic signed [15:0] act;
    logic               last;
  } act_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [5:0]  cfg_wdata  = '0;

  // model state and configuration copy
  logic signed [15:0] base_mem  [SEGS];
  logic signed [15:0] slope_mem [SEGS];
  logic               mdl_mode  = 1'b0;
  int                 mdl_shift = 0;

  // which entries the stimulus has already loaded
  bit base_loaded  [SEGS];
  bit slope_loaded [SEGS];

  req_t req_backlog  [$];
  act_t act_expected [$];
  req_t cur_req;

  int  reqs_queued   = 0;
  int  reqs_accepted = 0;
  int  errors        = 0;
  int  tanh_checked  = 0;
  int  leaky_checked = 0;
  int  table_writes  = 0;
  int  ignored_reqs  = 0;
  int  tx_gap        = 0;
  int  rx_stall      = 0;
  int  cycle_count   = 0;
  bit  no_idle       = 1'b0;
  logic rx_hold      = 1'b0;

  activation_tanh_leaky_unit #(
    .SEGMENTS  (SEGS),
    .FRAC_BITS (FRAC)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // table_index[11:0], value[27:12], zero pad
    .in_tuser   (in_tuser),   // operation[1:0]
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // activation[15:0]
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  always #5 clk = ~clk;

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // saturate to int16
  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // move a sample into the table domain and find its segment
  function automatic seg_t locate_segment(input logic signed [15:0] sample, input int shift);
    longint lim;
    longint v;
    int     q;
    seg_t   s;
    lim = longint'(SEGS / 2) << FRAC;
    q = shift + atlu_pkg::TANH_Q;
    if (q >= 0) begin
      if (q > 40) q = 40;
      v = longint'(sample) <<< q;
    end else begin
      v = longint'(sample) >>> (-q);
    end
    s.kind = SEG_INSIDE;
    s.idx  = '0;
    s.frac = '0;
    if (v >= lim - 1) s.kind = SEG_TOP;
    else if (v <= -lim) s.kind = SEG_BOTTOM;
    else begin
      s.idx  = 12'((v >>> FRAC) + SEGS / 2);
      s.frac = 6'(v & 63);
    end
    return s;
  endfunction

  // piecewise-linear tanh from the loaded tables
  function automatic logic signed [15:0] tanh_activation(input logic signed [15:0] sample);
    seg_t   s;
    longint interp;
    s = locate_segment(sample, mdl_shift);
    if (s.kind == SEG_TOP) return atlu_pkg::SAT_POS;
    if (s.kind == SEG_BOTTOM) return atlu_pkg::SAT_NEG;
    interp = (longint'(slope_mem[s.idx]) * longint'({1'b0, s.frac})) >>> FRAC;
    return clamp16(longint'(base_mem[s.idx]) + interp);
  endfunction

  // leaky relu with rounded q15 slope
  function automatic logic signed [15:0] leaky_activation(input logic signed [15:0] sample);
    if (sample >= 0) return sample;
    return clamp16((longint'(sample) * atlu_pkg::LEAKY_SLOPE + atlu_pkg::LEAKY_ROUND)
                   >>> atlu_pkg::LEAKY_SHIFT);
  endfunction

  // update tables or queue the activation an accepted request produces
  function automatic void absorb_request(input req_t r);
    act_t a;
    if (r.op == atlu_pkg::OP_EVAL) begin
      a.last = r.last;
      if (mdl_mode) begin
        a.act = leaky_activation(r.val);
        leaky_checked++;
      end else begin
        a.act = tanh_activation(r.val);
        tanh_checked++;
      end
      act_expected.push_back(a);
    end else if (r.op == atlu_pkg::OP_WR_BASE) begin
      base_mem[r.idx] = r.val;
      table_writes++;
    end else if (r.op == atlu_pkg::OP_WR_SLOPE) begin
      slope_mem[r.idx] = r.val;
      table_writes++;
    end else begin
      ignored_reqs++;
    end
  endfunction

  // idle length: mostly short, a few long
  function automatic int draw_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int rand_word();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
  endtask

  // compare one result against the oldest expectation
  task automatic check_result(input logic [15:0] got_act, input logic got_last);
    act_t want;
    if (act_expected.size() == 0) begin
      report_mismatch("result with no request pending", $signed(got_act), 0);
      return;
    end
    want = act_expected.pop_front();
    if ($signed(got_act) != want.act)
      report_mismatch("activation", $signed(got_act), want.act);
    if (got_last != want.last)
      report_mismatch("last flag", got_last, want.last);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_request(cur_req);
        reqs_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          cur_req = req_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0000, cur_req.val, cur_req.idx};
          in_tuser  <= cur_req.op;
          in_tlast  <= cur_req.last;
          tx_gap = draw_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata, out_tlast);
      if (rx_hold) begin
        out_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rx_stall = draw_gap();
      end
    end
  end

  task automatic push_item(input logic [1:0] op, input int idx, input int val, input bit last);
    req_t r;
    r.op   = op;
    r.idx  = 12'(idx);
    r.val  = 16'(val);
    r.last = last;
    if (op == atlu_pkg::OP_WR_BASE) base_loaded[r.idx] = 1'b1;
    if (op == atlu_pkg::OP_WR_SLOPE) slope_loaded[r.idx] = 1'b1;
    req_backlog.push_back(r);
    reqs_queued++;
  endtask

  // evaluate request, loading any table entry it reads that is still blank
  task automatic push_eval(input int val, input bit last);
    seg_t s;
    s = locate_segment(16'(val), mdl_shift);
    if (!mdl_mode && s.kind == SEG_INSIDE) begin
      if (!base_loaded[s.idx]) push_item(atlu_pkg::OP_WR_BASE, s.idx, rand_word(), 1'b0);
      if (!slope_loaded[s.idx]) push_item(atlu_pkg::OP_WR_SLOPE, s.idx, rand_word(), 1'b0);
    end
    push_item(atlu_pkg::OP_EVAL, $urandom_range(0, SEGS - 1), val, last);
  endtask

  task automatic write_cfg(input logic idx, input logic [5:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_mode(input logic mode, input int shift);
    write_cfg(atlu_pkg::CFG_ACT_MODE, {5'b00000, mode});
    write_cfg(atlu_pkg::CFG_PREACT_SHIFT, 6'(shift));
    mdl_mode  = mode;
    mdl_shift = shift;
    @(negedge clk);
  endtask

  // wait until all requests are in and all results are out
  task automatic wait_idle();
    while (reqs_accepted != reqs_queued || act_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // stimulus
  initial begin : stim
    int ph;
    int n;
    int r;
    int q;
    int bound;
    int val;
    int settle;
    logic mode;
    int shift;

    for (n = 0; n < SEGS; n++) begin
      base_mem[n]  = '0;
      slope_mem[n] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: small samples land inside the table, large ones saturate
    push_item(atlu_pkg::OP_WR_BASE, SEGS / 2, 1000, 1'b0);
    push_item(atlu_pkg::OP_WR_SLOPE, SEGS / 2, -2000, 1'b0);
    push_eval(0, 1'b0);
    push_eval(1, 1'b0);
    push_eval(-1, 1'b1);
    push_eval(32767, 1'b1);
    push_eval(-32768, 1'b0);
    push_item(OP_UNUSED, SEGS - 1, -1, 1'b1);
    push_eval(0, 1'b1);
    wait_idle();

    // range edges with extreme table words, interpolation overflow both ways
    set_mode(1'b0, -11);
    push_item(atlu_pkg::OP_WR_BASE, SEGS - 1, 32767, 1'b0);
    push_item(atlu_pkg::OP_WR_SLOPE, SEGS - 1, 32767, 1'b0);
    push_item(atlu_pkg::OP_WR_BASE, 0, -32768, 1'b0);
    push_item(atlu_pkg::OP_WR_SLOPE, 0, -32768, 1'b0);
    push_eval(16383, 1'b0);
    push_eval(16384, 1'b1);
    push_eval(-16384, 1'b0);
    push_eval(-16383, 1'b1);
    wait_idle();

    // leaky extremes and rounding
    set_mode(1'b1, 0);
    push_eval(0, 1'b0);
    push_eval(32767, 1'b0);
    push_eval(-1, 1'b1);
    push_eval(-32768, 1'b0);
    push_eval(-100, 1'b0);
    push_eval(-50, 1'b1);
    wait_idle();

    // random phases, each under its own setting
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        mode = 1'b0; shift = -30;
      end else if (ph == 1) begin
        mode = 1'b0; shift = 16;
      end else if (ph == 2) begin
        mode = 1'b1; shift = 5;
      end else if (ph == 3) begin
        mode = 1'b0; shift = -12;
      end else begin
        mode = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 9);
        if (r < 6) shift = $urandom_range(0, 7) - 15;
        else if (r < 8) shift = int'($urandom_range(0, 46)) - 30;
        else shift = (r == 8) ? -30 : 16;
      end
      set_mode(mode, shift);
      no_idle = (ph == 2 || ph == 7);

      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          r = $urandom_range(0, 99);
          q = mdl_shift + atlu_pkg::TANH_Q;
          if (r < 35) begin
            val = rand_word();
          end else if (r < 75) begin
            // mostly inside the table range for this shift
            if (q <= 0) begin
              val = rand_word();
            end else begin
              bound = (q > 17) ? 0 : (131072 >> q);
              val = int'($urandom_range(0, 2 * bound)) - bound;
              if (val > 32767) val = 32767;
              if (val < -32768) val = -32768;
            end
          end else begin
            val = int'($urandom_range(0, 255)) - 128;
          end
          push_eval(val, $urandom_range(0, 7) == 0);
        end else if (r < 80) begin
          push_item(atlu_pkg::OP_WR_BASE, $urandom_range(0, SEGS - 1), rand_word(),
                    $urandom_range(0, 1));
        end else if (r < 95) begin
          push_item(atlu_pkg::OP_WR_SLOPE, $urandom_range(0, SEGS - 1), rand_word(),
                    $urandom_range(0, 1));
        end else begin
          push_item(OP_UNUSED, $urandom_range(0, SEGS - 1), rand_word(),
                    $urandom_range(0, 1));
        end
      end

      // long receiver hold-off while requests keep coming
      if (ph == 3) begin
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
        @(negedge clk);
      end
      wait_idle();
    end
    no_idle = 1'b0;

    // final drain
    settle = 0;
    while (reqs_accepted != reqs_queued) @(negedge clk);
    while (act_expected.size() != 0 && settle < 5000) begin
      settle++;
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (act_expected.size() != 0)
      report_mismatch("results never delivered", 0, act_expected.size());

    $display("covered %0d tanh and %0d leaky activations, %0d table writes, %0d ignored",
             tanh_checked, leaky_checked, table_writes, ignored_reqs);
    $display("over %0d settings including shifts -30 and 16, in %0d cycles",
             PHASES + 3, cycle_count);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### activation_tanh_leaky_unit.f
+incdir+sv
sv/atlu_pkg.sv
sv/atlu_ram.sv
sv/atlu_prep.sv
sv/activation_tanh_leaky_unit.sv
sim/tb_activation_tanh_leaky_unit.sv
